>>> design/assert_macros.svh
// Assertion macros included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion on the standard clock and reset names.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

>>> design/plnp_pkg.sv
// Package: defaults, item classification codes and control struct.
package plnp_pkg;

   localparam int MAX_POINTS_DEF = 65536;
   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_SEG   = 2'd1,
      KIND_SKIP  = 2'd2
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic          last;
      logic          closed;
   } plnp_ctrl_type;

endpackage

>>> design/plnp_if.sv
// Channel interfaces: vertex request and nearest-point response.
interface plnp_req_if import plnp_pkg::*; #(
   parameter int CW = COORD_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] vertex_x;
   logic signed [CW-1:0] vertex_y;
   logic signed [CW-1:0] test_x;
   logic signed [CW-1:0] test_y;
   logic                 first_vertex;
   logic                 last_vertex;
   logic                 closed_path;

   modport source (output valid, vertex_x, vertex_y, test_x, test_y,
                   first_vertex, last_vertex, closed_path, input ready);
   modport sink   (input valid, vertex_x, vertex_y, test_x, test_y,
                   first_vertex, last_vertex, closed_path, output ready);
endinterface

interface plnp_rsp_if import plnp_pkg::*; #(
   parameter int CW = COORD_BITS_DEF,
   parameter int FW = FRAC_BITS_DEF,
   parameter int IW = $clog2(MAX_POINTS_DEF + 1)
);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] near_x;
   logic signed [CW-1:0] near_y;
   logic [FW+1:0]        global_param;
   logic [IW-1:0]        near_segment;
   logic [FW-1:0]        segment_param;
   logic                 segment_param_valid;

   modport source (output valid, near_x, near_y, global_param, near_segment,
                   segment_param, segment_param_valid, input ready);
   modport sink   (input valid, near_x, near_y, global_param, near_segment,
                   segment_param, segment_param_valid, output ready);
endinterface

>>> design/plnp_queue.sv
// Short FIFO between the classifying front and the compute back.
module plnp_queue import plnp_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output logic [W-1:0] pop_data
);
   localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CTW = $clog2(DEPTH + 1);

   logic [W-1:0]   entry_ff [DEPTH];
   logic [PTW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CTW-1:0] count_ff, count_in;

   assign full     = (count_ff == CTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> design/plnp_front.sv
// Front: accepts vertex words and classifies them as start, segment or skip.
module plnp_front import plnp_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int IW         = $clog2(MAX_POINTS_DEF + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_first,
   input  logic          in_last,
   input  logic          in_closed,
   input  logic          q_full,
   output logic          q_push,
   output plnp_ctrl_type q_ctrl,
   output logic [IW-1:0] q_cnt
);
   localparam logic [IW-1:0] MAXC = IW'(MAX_POINTS);

   logic          open_ff, open_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] cnt_next;

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;
   assign q_cnt    = cnt_next;

   always_comb begin
      q_ctrl.last   = in_last;
      q_ctrl.closed = in_closed;
      if (in_first || !open_ff) begin
         q_ctrl.kind = KIND_START;
         cnt_next    = IW'(1);
      end else if (cnt_ff < MAXC) begin
         q_ctrl.kind = KIND_SEG;
         cnt_next    = cnt_ff + 1'b1;
      end else begin
         // past the vertex limit: drop the vertex, keep the count
         q_ctrl.kind = KIND_SKIP;
         cnt_next    = cnt_ff;
      end
      open_in = open_ff;
      cnt_in  = cnt_ff;
      if (q_push) begin
         open_in = !in_last;
         cnt_in  = cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         open_ff <= open_in;
         cnt_ff  <= cnt_in;
      end
   end
endmodule

>>> design/plnp_back.sv
// Back: sequenced segment projection, distance compare and global parameter.
module plnp_back import plnp_pkg::*; #(
   parameter int CW = COORD_BITS_DEF,
   parameter int FW = FRAC_BITS_DEF,
   parameter int IW = $clog2(MAX_POINTS_DEF + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_pop,
   input  logic signed [CW-1:0] item_vx,
   input  logic signed [CW-1:0] item_vy,
   input  logic signed [CW-1:0] item_tx,
   input  logic signed [CW-1:0] item_ty,
   input  plnp_ctrl_type        item_ctrl,
   input  logic [IW-1:0]        item_cnt,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [CW-1:0] rsp_near_x,
   output logic signed [CW-1:0] rsp_near_y,
   output logic [FW+1:0]        rsp_global_param,
   output logic [IW-1:0]        rsp_near_segment,
   output logic [FW-1:0]        rsp_segment_param,
   output logic                 rsp_segment_param_valid
);
   localparam int DW  = CW + 1;
   localparam int MW  = (DW > FW + 1) ? DW : FW + 1;
   localparam int PW  = 2 * MW;
   localparam int SW  = 2 * CW + 3;
   localparam int NW  = IW + FW;
   localparam int GW  = FW + 2;
   localparam int CNW = $clog2(NW + 1);
   localparam logic [PW-1:0] HALF = PW'(1) << (FW - 1);
   localparam logic [GW-1:0] GMAX = '1;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_DIFF  = 12'b000000000010,
      ST_MUL   = 12'b000000000100,
      ST_TEST  = 12'b000000001000,
      ST_DIV   = 12'b000000010000,
      ST_PMUL  = 12'b000000100000,
      ST_DMUL  = 12'b000001000000,
      ST_UPD   = 12'b000010000000,
      ST_FIN   = 12'b000100000000,
      ST_GINIT = 12'b001000000000,
      ST_GDIV  = 12'b010000000000,
      ST_EMIT  = 12'b100000000000
   } state_type;

   typedef enum logic [1:0] {
      CAND_START = 2'd0,
      CAND_SEG   = 2'd1,
      CAND_VTX   = 2'd2
   } cand_type;

   state_type            state_ff, state_in;
   cand_type             cand_ff, cand_in;
   logic [CNW-1:0]       cnt_ff, cnt_in;
   logic signed [CW-1:0] test_x_ff, test_x_in, test_y_ff, test_y_in;
   logic signed [CW-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0] seg_x_ff, seg_x_in, seg_y_ff, seg_y_in;
   logic signed [CW-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic signed [DW-1:0] ux_ff, ux_in, uy_ff, uy_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [SW-1:0] uv_ff, uv_in, uu_ff, uu_in, d2_ff, d2_in;
   logic [SW-1:0]        rem_ff, rem_in;
   logic [FW-1:0]        q_ff, q_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 wrap_ff, wrap_in, last_ff, last_in, closed_ff, closed_in;
   logic [IW-1:0]        n_ff, n_in, seg_i_ff, seg_i_in;
   logic signed [SW-1:0] best_dist_ff, best_dist_in;
   logic signed [CW-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [IW-1:0]        best_base_ff, best_base_in, best_seg_ff, best_seg_in;
   logic [FW-1:0]        best_frac_ff, best_frac_in;
   logic                 best_fv_ff, best_fv_in;
   logic [IW-1:0]        gr_ff, gr_in, gdiv_ff, gdiv_in;
   logic [NW-1:0]        gn_ff, gn_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [GW-1:0]        rsp_g_ff, rsp_g_in;
   logic [IW-1:0]        rsp_seg_ff, rsp_seg_in;
   logic [FW-1:0]        rsp_frac_ff, rsp_frac_in;
   logic                 rsp_fv_ff, rsp_fv_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [DW-1:0] dx, dy;
   logic signed [PW-1:0] rnd_sum, rnd_shift;
   logic signed [CW-1:0] rnd_off;
   logic [SW:0]          rem_sh;
   logic [IW:0]          gtrial;
   logic                 win;

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_near_x              = rsp_x_ff;
   assign rsp_near_y              = rsp_y_ff;
   assign rsp_global_param        = rsp_g_ff;
   assign rsp_near_segment        = rsp_seg_ff;
   assign rsp_segment_param       = rsp_frac_ff;
   assign rsp_segment_param_valid = rsp_fv_ff;

   assign dx        = DW'(test_x_ff) - DW'(pt_x_ff);
   assign dy        = DW'(test_y_ff) - DW'(pt_y_ff);
   assign rnd_sum   = prod_ff + $signed(HALF);
   assign rnd_shift = rnd_sum >>> FW;
   assign rnd_off   = CW'(rnd_shift);
   assign rem_sh    = {rem_ff, 1'b0};
   assign gtrial    = {gr_ff, gn_ff[NW-1]};
   assign win       = (cand_ff == CAND_START) || (d2_ff < best_dist_ff);

   // one shared multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = MW'(ux_ff);
      mul_b = MW'(vx_ff);
      unique case (state_ff)
         ST_MUL: begin
            case (cnt_ff)
               CNW'(1): begin mul_a = MW'(uy_ff); mul_b = MW'(vy_ff); end
               CNW'(2): begin mul_a = MW'(ux_ff); mul_b = MW'(ux_ff); end
               CNW'(3): begin mul_a = MW'(uy_ff); mul_b = MW'(uy_ff); end
               default: begin mul_a = MW'(ux_ff); mul_b = MW'(vx_ff); end
            endcase
         end
         ST_PMUL: begin
            mul_a = (cnt_ff == '0) ? MW'(ux_ff) : MW'(uy_ff);
            mul_b = MW'($signed({1'b0, q_ff}));
         end
         ST_DMUL: begin
            mul_a = (cnt_ff == '0) ? MW'(dx) : MW'(dy);
            mul_b = mul_a;
         end
         default: begin
            mul_a = MW'(ux_ff);
            mul_b = MW'(vx_ff);
         end
      endcase
      prod_in = PW'(mul_a * mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      cnt_in       = cnt_ff;
      test_x_in    = test_x_ff;
      test_y_in    = test_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      seg_x_in     = seg_x_ff;
      seg_y_in     = seg_y_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      uv_in        = uv_ff;
      uu_in        = uu_ff;
      d2_in        = d2_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      wrap_in      = wrap_ff;
      last_in      = last_ff;
      closed_in    = closed_ff;
      n_in         = n_ff;
      seg_i_in     = seg_i_ff;
      best_dist_in = best_dist_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      best_base_in = best_base_ff;
      best_seg_in  = best_seg_ff;
      best_frac_in = best_frac_ff;
      best_fv_in   = best_fv_ff;
      gr_in        = gr_ff;
      gdiv_in      = gdiv_ff;
      gn_in        = gn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_fv_in    = rsp_fv_ff;
      item_pop     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               last_in  = item_ctrl.last;
               n_in     = item_cnt;
               cnt_in   = '0;
               case (item_ctrl.kind)
                  KIND_START: begin
                     test_x_in  = item_tx;
                     test_y_in  = item_ty;
                     closed_in  = item_ctrl.closed;
                     start_x_in = item_vx;
                     start_y_in = item_vy;
                     prev_x_in  = item_vx;
                     prev_y_in  = item_vy;
                     pt_x_in    = item_vx;
                     pt_y_in    = item_vy;
                     cand_in    = CAND_START;
                     state_in   = ST_DMUL;
                  end
                  KIND_SEG: begin
                     seg_x_in = item_vx;
                     seg_y_in = item_vy;
                     seg_i_in = item_cnt - 1'b1;
                     wrap_in  = 1'b0;
                     state_in = ST_DIFF;
                  end
                  default: begin
                     state_in = item_ctrl.last ? ST_FIN : ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIFF: begin
            ux_in    = DW'(seg_x_ff) - DW'(prev_x_ff);
            uy_in    = DW'(seg_y_ff) - DW'(prev_y_ff);
            vx_in    = DW'(test_x_ff) - DW'(prev_x_ff);
            vy_in    = DW'(test_y_ff) - DW'(prev_y_ff);
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               CNW'(1): uv_in = SW'(prod_ff);
               CNW'(2): uv_in = uv_ff + SW'(prod_ff);
               CNW'(3): uu_in = SW'(prod_ff);
               CNW'(4): begin
                  uu_in    = uu_ff + SW'(prod_ff);
                  state_in = ST_TEST;
               end
               default: ;
            endcase
         end
         ST_TEST: begin
            cnt_in = '0;
            if (uv_ff > 0 && uv_ff < uu_ff) begin
               rem_in   = uv_ff;
               q_in     = '0;
               state_in = ST_DIV;
            end else if (wrap_ff) begin
               state_in = ST_GINIT;
            end else begin
               pt_x_in  = seg_x_ff;
               pt_y_in  = seg_y_ff;
               cand_in  = CAND_VTX;
               state_in = ST_DMUL;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, uu_ff}) begin
               rem_in = SW'(rem_sh - {1'b0, uu_ff});
               q_in   = {q_ff[FW-2:0], 1'b1};
            end else begin
               rem_in = SW'(rem_sh);
               q_in   = {q_ff[FW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNW'(FW - 1)) begin
               cnt_in   = '0;
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNW'(1)) begin
               pt_x_in = prev_x_ff + rnd_off;
            end
            if (cnt_ff == CNW'(2)) begin
               pt_y_in  = prev_y_ff + rnd_off;
               cand_in  = CAND_SEG;
               cnt_in   = '0;
               state_in = ST_DMUL;
            end
         end
         ST_DMUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNW'(1)) begin
               d2_in = SW'(prod_ff);
            end
            if (cnt_ff == CNW'(2)) begin
               d2_in    = d2_ff + SW'(prod_ff);
               cnt_in   = '0;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (win) begin
               best_dist_in = d2_ff;
               best_x_in    = pt_x_ff;
               best_y_in    = pt_y_ff;
               case (cand_ff)
                  CAND_START: begin
                     best_base_in = '0;
                     best_frac_in = '0;
                     best_seg_in  = '0;
                     best_fv_in   = 1'b0;
                  end
                  CAND_SEG: begin
                     best_base_in = seg_i_ff - 1'b1;
                     best_frac_in = q_ff;
                     best_seg_in  = seg_i_ff;
                     best_fv_in   = 1'b1;
                  end
                  default: begin
                     best_base_in = seg_i_ff;
                     best_seg_in  = seg_i_ff;
                     best_fv_in   = 1'b0;
                  end
               endcase
            end
            case (cand_ff)
               CAND_SEG: begin
                  if (wrap_ff) begin
                     state_in = ST_GINIT;
                  end else begin
                     pt_x_in  = seg_x_ff;
                     pt_y_in  = seg_y_ff;
                     cand_in  = CAND_VTX;
                     state_in = ST_DMUL;
                  end
               end
               CAND_VTX: begin
                  prev_x_in = seg_x_ff;
                  prev_y_in = seg_y_ff;
                  state_in  = last_ff ? ST_FIN : ST_IDLE;
               end
               default: begin
                  state_in = last_ff ? ST_FIN : ST_IDLE;
               end
            endcase
         end
         ST_FIN: begin
            if (closed_ff) begin
               // wrap segment back to vertex 0
               seg_x_in = start_x_ff;
               seg_y_in = start_y_ff;
               seg_i_in = n_ff;
               wrap_in  = 1'b1;
               state_in = ST_DIFF;
            end else begin
               state_in = ST_GINIT;
            end
         end
         ST_GINIT: begin
            gn_in    = (NW'(best_base_ff) << FW) + (best_fv_ff ? NW'(best_frac_ff) : '0);
            gdiv_in  = (n_ff > IW'(1)) ? n_ff - 1'b1 : IW'(1);
            gr_in    = '0;
            cnt_in   = '0;
            state_in = ST_GDIV;
         end
         ST_GDIV: begin
            if (gtrial >= {1'b0, gdiv_ff}) begin
               gr_in = IW'(gtrial - {1'b0, gdiv_ff});
               gn_in = {gn_ff[NW-2:0], 1'b1};
            end else begin
               gr_in = IW'(gtrial);
               gn_in = {gn_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNW'(NW - 1)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = best_x_ff;
               rsp_y_in     = best_y_ff;
               rsp_g_in     = (gn_ff > NW'(GMAX)) ? GMAX : GW'(gn_ff);
               rsp_seg_in   = best_seg_ff;
               rsp_frac_in  = best_frac_ff;
               rsp_fv_in    = best_fv_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      cnt_ff       <= cnt_in;
      test_x_ff    <= test_x_in;
      test_y_ff    <= test_y_in;
      start_x_ff   <= start_x_in;
      start_y_ff   <= start_y_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      seg_x_ff     <= seg_x_in;
      seg_y_ff     <= seg_y_in;
      pt_x_ff      <= pt_x_in;
      pt_y_ff      <= pt_y_in;
      ux_ff        <= ux_in;
      uy_ff        <= uy_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      uv_ff        <= uv_in;
      uu_ff        <= uu_in;
      d2_ff        <= d2_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      prod_ff      <= prod_in;
      wrap_ff      <= wrap_in;
      last_ff      <= last_in;
      closed_ff    <= closed_in;
      n_ff         <= n_in;
      seg_i_ff     <= seg_i_in;
      best_dist_ff <= best_dist_in;
      best_x_ff    <= best_x_in;
      best_y_ff    <= best_y_in;
      best_base_ff <= best_base_in;
      best_seg_ff  <= best_seg_in;
      best_frac_ff <= best_frac_in;
      best_fv_ff   <= best_fv_in;
      gr_ff        <= gr_in;
      gdiv_ff      <= gdiv_in;
      gn_ff        <= gn_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_g_ff     <= rsp_g_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_fv_ff    <= rsp_fv_in;
   end
endmodule

>>> design/polyline_nearest_point_2d_top.sv
// Top level: nearest point on a streamed 2D polyline.
//
//   channel | dir | payload                                        | handshake
//   req_ch  | in  | vertex, test point, first/last/closed flags    | valid/ready
//   rsp_ch  | out | near point, global/segment param, segment idx  | valid/ready
//
// The back handles the first vertex of a query as a distance check only. Each
// further vertex is sequenced through the single shared multiplier and the
// one-bit-per-cycle fraction divider. The last vertex adds the wrap segment
// when closed, then the global-parameter divider. A two-word queue lets the
// front keep accepting while the back works; a waiting response holds only
// the final emit step.
// Reset is synchronous and clears control state only.
module polyline_nearest_point_2d_top import plnp_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   plnp_req_if.sink  req_ch,
   plnp_rsp_if.source rsp_ch
);
   localparam int CW = COORD_BITS;
   localparam int IW = $clog2(MAX_POINTS + 1);
   localparam int QW = 4 * CW + $bits(plnp_ctrl_type) + IW;

   logic                 q_full, q_push, q_empty, q_pop;
   plnp_ctrl_type        f_ctrl, b_ctrl;
   logic [IW-1:0]        f_cnt, b_cnt;
   logic [QW-1:0]        push_data, pop_data;
   logic signed [CW-1:0] b_vx, b_vy, b_tx, b_ty;

   plnp_front #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_first  (req_ch.first_vertex),
      .in_last   (req_ch.last_vertex),
      .in_closed (req_ch.closed_path),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_ctrl    (f_ctrl),
      .q_cnt     (f_cnt)
   );

   assign push_data = {req_ch.vertex_x, req_ch.vertex_y, req_ch.test_x, req_ch.test_y,
                       f_ctrl, f_cnt};

   plnp_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (pop_data)
   );

   assign {b_vx, b_vy, b_tx, b_ty, b_ctrl, b_cnt} = pop_data;

   plnp_back #(.CW(CW), .FW(FRAC_BITS), .IW(IW)) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .item_valid              (!q_empty),
      .item_pop                (q_pop),
      .item_vx                 (b_vx),
      .item_vy                 (b_vy),
      .item_tx                 (b_tx),
      .item_ty                 (b_ty),
      .item_ctrl               (b_ctrl),
      .item_cnt                (b_cnt),
      .rsp_valid               (rsp_ch.valid),
      .rsp_ready               (rsp_ch.ready),
      .rsp_near_x              (rsp_ch.near_x),
      .rsp_near_y              (rsp_ch.near_y),
      .rsp_global_param        (rsp_ch.global_param),
      .rsp_near_segment        (rsp_ch.near_segment),
      .rsp_segment_param       (rsp_ch.segment_param),
      .rsp_segment_param_valid (rsp_ch.segment_param_valid)
   );
endmodule

>>> design/plnp_checker.sv
// Checker on the response port of the top level, with its bind.
`include "assert_macros.svh"

module plnp_checker import plnp_pkg::*; #(
   parameter int CW = COORD_BITS_DEF,
   parameter int FW = FRAC_BITS_DEF,
   parameter int IW = $clog2(MAX_POINTS_DEF + 1)
) (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [CW-1:0] near_x,
   input logic [IW-1:0] near_segment,
   input logic [FW+1:0] global_param,
   input logic          segment_param_valid
);
   `ASSERT_STD(a_out_clear_after_reset, $past(reset) |-> !rsp_valid, "response right after reset")
   `ASSERT_STD(a_stall_holds, rsp_valid && !rsp_ready |=> rsp_valid && $stable(near_x), "stalled word changed")
   `ASSERT_STD(a_vertex0_no_frac, rsp_valid && near_segment == '0 |-> !segment_param_valid, "segment 0 marked interior")
   `ASSERT_STD(a_vertex0_param, rsp_valid && near_segment == '0 |-> global_param == '0, "vertex 0 with nonzero parameter")
endmodule

bind polyline_nearest_point_2d_top plnp_checker #(
   .CW(COORD_BITS), .FW(FRAC_BITS), .IW($clog2(MAX_POINTS + 1))
) u_plnp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .near_x              (rsp_ch.near_x),
   .near_segment        (rsp_ch.near_segment),
   .global_param        (rsp_ch.global_param),
   .segment_param_valid (rsp_ch.segment_param_valid)
);

>>> bench/testbench.sv
// Testbench for the streamed polyline nearest-point block: directed table, then random queries.
`timescale 1ns / 1ps

module testbench;
   import plnp_pkg::*;

   typedef struct {
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic signed [23:0] tx;
      logic signed [23:0] ty;
      bit                 first;
      bit                 last;
      bit                 closed;
   } vertex_word_t;

   typedef struct {
      logic signed [23:0] nx;
      logic signed [23:0] ny;
      logic [17:0]        gp;
      logic [16:0]        seg;
      logic [15:0]        sp;
      bit                 spv;
   } nearest_word_t;

   typedef struct {
      vertex_word_t  word;
      bit            typed;
      nearest_word_t want;
   } table_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plnp_req_if req_ch ();
   plnp_rsp_if rsp_ch ();

   polyline_nearest_point_2d_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint      tp_x, tp_y, sv_x, sv_y, pv_x, pv_y;
   int unsigned vtx_count;
   bit          closed_q;
   longint      best_d2, best_px, best_py;
   int unsigned best_base, best_frac, best_seg;
   bit          best_frac_ok;

   nearest_word_t nearest_pending[$];
   table_row_t    stim_table[$];
   int            mismatches = 0;
   int            results_seen = 0;
   int            words_sent = 0;
   int            queries_sent = 0;
   int            idle_max = 13;

   function automatic longint dist2(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = ax - bx;
      dy = ay - by;
      return dx * dx + dy * dy;
   endfunction

   function automatic void try_interior(longint x0, longint y0, longint x1, longint y1,
                                        int unsigned i);
      longint ux, uy, uv, uu, r, q, px, py, d2;
      ux = x1 - x0;
      uy = y1 - y0;
      uv = ux * (tp_x - x0) + uy * (tp_y - y0);
      uu = ux * ux + uy * uy;
      if (!(uv > 0 && uv < uu)) return;
      r = uv;
      q = 0;
      for (int k = 0; k < 16; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= uu) begin
            r = r - uu;
            q = q | 1;
         end
      end
      px = x0 + ((ux * q + 32768) >>> 16);
      py = y0 + ((uy * q + 32768) >>> 16);
      d2 = dist2(tp_x, tp_y, px, py);
      if (d2 < best_d2) begin
         best_d2 = d2;
         best_px = px;
         best_py = py;
         best_base = i - 1;
         best_frac = q;
         best_seg = i;
         best_frac_ok = 1;
      end
   endfunction

   function automatic void try_corner(longint x, longint y, int unsigned i);
      longint d2;
      d2 = dist2(tp_x, tp_y, x, y);
      if (d2 < best_d2) begin
         best_d2 = d2;
         best_px = x;
         best_py = y;
         best_base = i;
         best_seg = i;
         best_frac_ok = 0;
      end
   endfunction

   function automatic bit predict_nearest(vertex_word_t w, output nearest_word_t res);
      longint      x, y, num, dv, g;
      int unsigned n;
      x = w.vx;
      y = w.vy;
      res = '{default: 0};
      if (w.first || vtx_count == 0) begin
         tp_x = w.tx;
         tp_y = w.ty;
         closed_q = w.closed;
         sv_x = x;
         sv_y = y;
         pv_x = x;
         pv_y = y;
         vtx_count = 1;
         best_d2 = dist2(tp_x, tp_y, x, y);
         best_px = x;
         best_py = y;
         best_base = 0;
         best_frac = 0;
         best_seg = 0;
         best_frac_ok = 0;
      end else if (vtx_count < MAX_POINTS_DEF) begin
         try_interior(pv_x, pv_y, x, y, vtx_count);
         try_corner(x, y, vtx_count);
         pv_x = x;
         pv_y = y;
         vtx_count++;
      end
      if (!w.last) return 0;
      n = vtx_count;
      if (closed_q) try_interior(pv_x, pv_y, sv_x, sv_y, n);
      dv = (n > 1) ? n - 1 : 1;
      num = (longint'(best_base) << 16) + (best_frac_ok ? best_frac : 0);
      g = num / dv;
      if (g > 262143) g = 262143;
      res.nx = best_px[23:0];
      res.ny = best_py[23:0];
      res.gp = g[17:0];
      res.seg = best_seg[16:0];
      res.sp = best_frac[15:0];
      res.spv = best_frac_ok;
      vtx_count = 0;
      return 1;
   endfunction

   function automatic void add_row(longint vx, longint vy, longint tx, longint ty,
                                   bit f, bit l, bit c, bit typed = 0,
                                   nearest_word_t want = '{default: 0});
      table_row_t row;
      row.word = '{vx[23:0], vy[23:0], tx[23:0], ty[23:0], f, l, c};
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endfunction

   function automatic logic signed [23:0] rand_coord(int mode);
      case (mode)
         0: return $urandom_range(0, 400) - 200;
         1: return $urandom_range(0, 200000) - 100000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_word(vertex_word_t w, bit typed, nearest_word_t want);
      int            gap;
      nearest_word_t res;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.vertex_x     <= w.vx;
      req_ch.vertex_y     <= w.vy;
      req_ch.test_x       <= w.tx;
      req_ch.test_y       <= w.ty;
      req_ch.first_vertex <= w.first;
      req_ch.last_vertex  <= w.last;
      req_ch.closed_path  <= w.closed;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (predict_nearest(w, res)) begin
         queries_sent++;
         nearest_pending.push_back(typed ? want : res);
      end
   endtask

   // response side: random stalls, check each word against the oldest expectation
   initial begin
      int            gap;
      nearest_word_t exp_w;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, idle_max);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         results_seen++;
         if (nearest_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: x=%0d y=%0d", rsp_ch.near_x, rsp_ch.near_y);
         end else begin
            exp_w = nearest_pending.pop_front();
            if (rsp_ch.near_x !== exp_w.nx || rsp_ch.near_y !== exp_w.ny ||
                rsp_ch.global_param !== exp_w.gp || rsp_ch.near_segment !== exp_w.seg ||
                rsp_ch.segment_param !== exp_w.sp ||
                rsp_ch.segment_param_valid !== exp_w.spv) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%0d y=%0d gp=%0d seg=%0d sp=%0d v=%0d | got x=%0d y=%0d gp=%0d seg=%0d sp=%0d v=%0d",
                           exp_w.nx, exp_w.ny, exp_w.gp, exp_w.seg, exp_w.sp, exp_w.spv,
                           rsp_ch.near_x, rsp_ch.near_y, rsp_ch.global_param,
                           rsp_ch.near_segment, rsp_ch.segment_param,
                           rsp_ch.segment_param_valid);
            end
         end
      end
   end

   initial begin
      vertex_word_t  w;
      nearest_word_t none;
      int            len, mode, noise;
      bit            drained;
      none = '{default: 0};
      drained = 0;
      vtx_count = 0;
      req_ch.valid        <= 1'b0;
      req_ch.vertex_x     <= '0;
      req_ch.vertex_y     <= '0;
      req_ch.test_x       <= '0;
      req_ch.test_y       <= '0;
      req_ch.first_vertex <= 1'b0;
      req_ch.last_vertex  <= 1'b0;
      req_ch.closed_path  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single vertex at the extremes, open and closed
      add_row(-8388608, 8388607, 8388607, -8388608, 1, 1, 0, 1,
              '{-24'sd8388608, 24'sd8388607, 0, 0, 0, 0});
      add_row(8388607, -8388608, -8388608, 8388607, 1, 1, 1, 1,
              '{24'sd8388607, -24'sd8388608, 0, 0, 0, 0});
      // no query open: the word starts one without first_vertex
      add_row(0, 0, 123, -77, 0, 1, 0, 1, '{24'sd0, 24'sd0, 0, 0, 0, 0});
      // first_vertex mid-query drops the open query
      add_row(0, 0, 5, 5, 1, 0, 0);
      add_row(40, 0, 5, 5, 0, 0, 0);
      add_row(10, 0, 0, 10, 1, 0, 0);
      add_row(-10, 0, 0, 10, 0, 1, 0);
      // closed square, nearest on the wrap segment
      add_row(0, 0, -1, 50, 1, 0, 1);
      add_row(100, 0, 0, 0, 0, 0, 0);
      add_row(100, 100, 0, 0, 0, 0, 0);
      add_row(0, 100, 0, 0, 0, 1, 0);
      // equal vertex distances; the second segment passes through the test point
      add_row(-5, 0, 0, 3, 1, 0, 0);
      add_row(5, 0, 0, 0, 0, 0, 0);
      add_row(-5, 6, 0, 0, 0, 1, 0);
      // full-span diagonal segment
      add_row(-8388608, -8388608, 8388607, -8388608, 1, 0, 0);
      add_row(8388607, 8388607, 0, 0, 0, 1, 0);
      // two-vertex closed path: first and wrap segments tie, the first is kept
      add_row(0, 0, 7, 1, 1, 0, 1);
      add_row(8, 0, 0, 0, 0, 1, 0);
      // odd rounding on a short steep segment
      add_row(0, 0, 3, 1, 1, 0, 0);
      add_row(1, 7, 0, 0, 0, 0, 0);
      add_row(3, -2, 0, 0, 0, 1, 1);

      foreach (stim_table[i]) send_word(stim_table[i].word, stim_table[i].typed,
                                        stim_table[i].want);

      while (words_sent < 1920) begin
         if (words_sent % 300 < 60) idle_max = 0;
         else idle_max = 13;
         // hold until the block has drained once
         if (!drained && words_sent > 1000) begin
            drained = 1;
            req_ch.valid <= 1'b0;
            wait (nearest_pending.size() == 0);
            repeat (100) @(posedge clock);
         end
         noise = $urandom_range(0, 99);
         mode = $urandom_range(0, 2);
         if (noise < 8) begin
            w.vx = rand_coord(mode);
            w.vy = rand_coord(mode);
            w.tx = rand_coord(mode);
            w.ty = rand_coord(mode);
            w.first = $urandom();
            w.last = $urandom();
            w.closed = $urandom();
            send_word(w, 0, none);
         end else begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 7);
            w.tx = rand_coord(mode);
            w.ty = rand_coord(mode);
            w.closed = $urandom();
            for (int k = 0; k < len; k++) begin
               w.vx = rand_coord(mode);
               w.vy = rand_coord(mode);
               w.first = (k == 0);
               w.last = (k == len - 1) && (noise >= 13);
               send_word(w, 0, none);
               if (k == 0) begin
                  w.tx = rand_coord(2);
                  w.ty = rand_coord(2);
                  w.closed = $urandom();
               end
            end
         end
      end
      req_ch.valid <= 1'b0;
      wait (nearest_pending.size() == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d vertex words in %0d finished queries, %0d results checked",
               words_sent, queries_sent, results_seen);
      if (mismatches == 0 && nearest_pending.size() == 0) begin
         $display("** polyline_nearest_point_2d_top: PASSED **");
      end else begin
         $display("mismatches: %0d", mismatches);
         $display("** polyline_nearest_point_2d_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", nearest_pending.size());
      $display("** polyline_nearest_point_2d_top: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/plnp_pkg.sv
design/plnp_if.sv
design/plnp_queue.sv
design/plnp_front.sv
design/plnp_back.sv
design/polyline_nearest_point_2d_top.sv
design/plnp_checker.sv
bench/testbench.sv
